>>> rtl/etdp_pkg.sv
// ----------------------------------------------------------------------------
// etdp_pkg
// Types and constants shared by the edge and target drive policy modules.
// ----------------------------------------------------------------------------
package etdp_pkg;

    localparam int EDGE_W  = 4;
    localparam int RANGE_W = 6;
    localparam int DRIVE_W = 9;
    localparam int HOLD_W  = 6;
    localparam int ATK_W   = 3;

    typedef logic signed [DRIVE_W-1:0] drive_t;
    typedef logic [HOLD_W-1:0]         hold_t;

    // Speed magnitudes
    localparam drive_t SPD_FULL   = 9'sd200;
    localparam drive_t SPD_FAST   = 9'sd180;
    localparam drive_t SPD_CHARGE = 9'sd140;
    localparam drive_t SPD_ESC    = 9'sd120;
    localparam drive_t SPD_STEER  = 9'sd110;
    localparam drive_t SPD_TURN   = 9'sd100;
    localparam drive_t SPD_SEARCH = 9'sd80;
    localparam drive_t SPD_SLOW   = 9'sd70;
    localparam drive_t SPD_CRAWL  = 9'sd60;
    localparam drive_t SPD_STOP   = 9'sd0;

    // Hold times in milliseconds
    localparam hold_t HOLD_NONE   = 6'd0;
    localparam hold_t HOLD_BRAKE  = 6'd2;
    localparam hold_t HOLD_PULSE  = 6'd3;
    localparam hold_t HOLD_ESC_F  = 6'd20;
    localparam hold_t HOLD_ESC_R  = 6'd30;
    localparam hold_t HOLD_OPEN   = 6'd50;
    localparam hold_t HOLD_FIRST  = 6'd60;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture snapshot decode and update policy state
        logic emit_pulse;  // load a pulse command into the output stage
        logic emit_final;  // load the closing command into the output stage
        logic pulse_on;    // driving half of an on/off pulse
    } etdp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic has_cmd;     // current snapshot produces commands
        logic has_pulses;  // current snapshot starts with a pulse train
        logic out_free;    // output stage can take a command this cycle
    } etdp_sts_t;

endpackage

>>> rtl/etdp_ctrl.sv
// ----------------------------------------------------------------------------
// etdp_ctrl
// Sequencer: takes a snapshot, walks any pulse train, then the closing command.
// ----------------------------------------------------------------------------
module etdp_ctrl
    import etdp_pkg::*;
#(
    parameter int PULSE_COUNT = 7
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  etdp_sts_t sts,
    output etdp_cmd_t cmd
);

    localparam int STEPS = 2 * PULSE_COUNT;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PULSE,
        ST_FINAL
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    // Hold off requests while reset is applied
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd.load       = 1'b0;
        cmd.emit_pulse = 1'b0;
        cmd.emit_final = 1'b0;
        cmd.pulse_on   = ~cnt_reg[0];
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (!sts.has_cmd) begin
                        state_next = ST_IDLE;
                    end else if (sts.has_pulses) begin
                        state_next = ST_PULSE;
                    end else begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_PULSE: begin
                if (sts.out_free) begin
                    cmd.emit_pulse = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (sts.out_free) begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/etdp_datapath.sv
// ----------------------------------------------------------------------------
// etdp_datapath
// Snapshot decode, policy state, closing command store and output stage.
// ----------------------------------------------------------------------------
module etdp_datapath
    import etdp_pkg::*;
#(
    parameter int ATTACK_HOLD = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [EDGE_W-1:0]  edge_hits,
    input  logic [RANGE_W-1:0] range_hits,
    input  etdp_cmd_t          cmd,
    output etdp_sts_t          sts,
    output logic               m_tvalid,
    input  logic               m_tready,
    output drive_t             left_drive,
    output drive_t             right_drive,
    output hold_t              hold_ms,
    output logic               last_of_run
);

    localparam logic [ATK_W-1:0] ATK_RELOAD = ATK_W'(ATTACK_HOLD);

    // Policy state
    logic             reverse_reg, reverse_next;
    logic             turn_left_reg, turn_left_next;
    logic [ATK_W-1:0] attack_reg, attack_next;
    logic             first_reg, first_next;
    logic             spin_reg, spin_next;

    // Captured run
    logic   pulse_neg_reg, pulse_neg_next;
    drive_t fin_left_reg, fin_left_next;
    drive_t fin_right_reg, fin_right_next;
    hold_t  fin_hold_reg, fin_hold_next;

    // Output stage
    logic   valid_reg, valid_next;
    drive_t left_reg, left_next;
    drive_t right_reg, right_next;
    hold_t  hold_reg, hold_next;
    logic   last_reg, last_next;

    logic fl, fr, rr, rl;
    logic s1, s2, s3, s4, s5, s6;
    logic front_pair, rear_pair, skip, pulses;
    drive_t pulse_spd;

    assign fl = edge_hits[0];
    assign fr = edge_hits[1];
    assign rr = edge_hits[2];
    assign rl = edge_hits[3];
    assign s1 = range_hits[0];
    assign s2 = range_hits[1];
    assign s3 = range_hits[2];
    assign s4 = range_hits[3];
    assign s5 = range_hits[4];
    assign s6 = range_hits[5];
    assign front_pair = s1 && s2;
    assign rear_pair  = s4 && s5;

    // Spin in progress ignores snapshots without a front, rear or edge hit
    assign skip = spin_reg && !s1 && !s2 && !s4 && !s5 && (edge_hits == '0);

    always_comb begin
        reverse_next   = reverse_reg;
        turn_left_next = turn_left_reg;
        attack_next    = attack_reg;
        first_next     = first_reg;
        spin_next      = spin_reg && skip;
        pulses         = 1'b0;
        pulse_neg_next = 1'b0;
        fin_left_next  = SPD_STOP;
        fin_right_next = SPD_STOP;
        fin_hold_next  = HOLD_NONE;
        if (skip) begin
            spin_next = 1'b1;
        end else if (fl && rl) begin
            fin_left_next  = -SPD_TURN;
            fin_right_next = SPD_TURN;
            fin_hold_next  = HOLD_ESC_R;
            reverse_next   = 1'b1;
        end else if (fr && rr) begin
            fin_left_next  = SPD_TURN;
            fin_right_next = -SPD_TURN;
            fin_hold_next  = HOLD_ESC_R;
            reverse_next   = 1'b0;
        end else if (fl || fr) begin
            pulses         = 1'b1;
            pulse_neg_next = 1'b1;
            reverse_next   = 1'b0;
            first_next     = 1'b0;
            if (first_reg) begin
                fin_left_next  = fl ? -SPD_FULL : -SPD_TURN;
                fin_right_next = fl ? -SPD_TURN : -SPD_FULL;
                fin_hold_next  = HOLD_FIRST;
            end else begin
                fin_left_next  = fl ? -SPD_FAST : -SPD_ESC;
                fin_right_next = fl ? -SPD_ESC : -SPD_FAST;
                fin_hold_next  = HOLD_ESC_F;
            end
        end else if (rr || rl) begin
            pulses       = 1'b1;
            reverse_next = 1'b1;
            first_next   = 1'b0;
            if (first_reg) begin
                fin_left_next  = rr ? SPD_FULL : SPD_TURN;
                fin_right_next = rr ? SPD_TURN : SPD_FULL;
                fin_hold_next  = HOLD_FIRST;
            end else begin
                fin_left_next  = rr ? SPD_FAST : SPD_ESC;
                fin_right_next = rr ? SPD_ESC : SPD_FAST;
                fin_hold_next  = HOLD_ESC_R;
            end
        end else if ((attack_reg != '0) && !front_pair && !rear_pair) begin
            fin_hold_next = HOLD_BRAKE;
            attack_next   = attack_reg - 1'b1;
        end else if (front_pair) begin
            reverse_next   = 1'b0;
            fin_left_next  = SPD_CHARGE;
            fin_right_next = SPD_CHARGE;
            attack_next    = ATK_RELOAD;
        end else if (s1) begin
            reverse_next   = 1'b0;
            fin_left_next  = SPD_STEER;
            fin_right_next = SPD_SLOW;
            turn_left_next = 1'b1;
        end else if (s2) begin
            reverse_next   = 1'b0;
            fin_left_next  = SPD_SLOW;
            fin_right_next = SPD_STEER;
            turn_left_next = 1'b0;
        end else if (rear_pair) begin
            reverse_next   = 1'b1;
            fin_left_next  = -SPD_CHARGE;
            fin_right_next = -SPD_CHARGE;
            attack_next    = ATK_RELOAD;
        end else if (s5) begin
            reverse_next   = 1'b1;
            fin_left_next  = -SPD_STEER;
            fin_right_next = -SPD_SLOW;
            turn_left_next = 1'b1;
        end else if (s4) begin
            reverse_next   = 1'b1;
            fin_left_next  = -SPD_SLOW;
            fin_right_next = -SPD_STEER;
            turn_left_next = 1'b0;
        end else if (first_reg) begin
            // Opening move, backward unless the reverse flag is set, then forward
            fin_left_next  = turn_left_reg ? SPD_CHARGE : SPD_FAST;
            fin_right_next = turn_left_reg ? SPD_FAST : SPD_CHARGE;
            if (!reverse_reg) begin
                fin_left_next  = -fin_left_next;
                fin_right_next = -fin_right_next;
            end
            fin_hold_next = HOLD_OPEN;
            first_next    = 1'b0;
        end else if (s3) begin
            turn_left_next = 1'b0;
            fin_left_next  = SPD_ESC;
            fin_right_next = -SPD_SLOW;
            spin_next      = 1'b1;
        end else if (s6) begin
            turn_left_next = 1'b1;
            fin_left_next  = -SPD_ESC;
            fin_right_next = SPD_SLOW;
            spin_next      = 1'b1;
        end else begin
            fin_left_next  = turn_left_reg ? SPD_CRAWL : SPD_SEARCH;
            fin_right_next = turn_left_reg ? SPD_SEARCH : SPD_CRAWL;
            if (!reverse_reg) begin
                fin_left_next  = -fin_left_next;
                fin_right_next = -fin_right_next;
            end
        end
    end

    assign sts.has_cmd    = !skip;
    assign sts.has_pulses = pulses;
    assign sts.out_free   = !valid_reg || m_tready;

    assign pulse_spd = pulse_neg_reg ? -SPD_FULL : SPD_FULL;

    always_comb begin
        valid_next = valid_reg && !m_tready;
        left_next  = left_reg;
        right_next = right_reg;
        hold_next  = hold_reg;
        last_next  = last_reg;
        if (cmd.emit_pulse) begin
            valid_next = 1'b1;
            left_next  = cmd.pulse_on ? pulse_spd : SPD_STOP;
            right_next = cmd.pulse_on ? pulse_spd : SPD_STOP;
            hold_next  = HOLD_PULSE;
            last_next  = 1'b0;
        end else if (cmd.emit_final) begin
            valid_next = 1'b1;
            left_next  = fin_left_reg;
            right_next = fin_right_reg;
            hold_next  = fin_hold_reg;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_reg   <= 1'b0;
            turn_left_reg <= 1'b0;
            attack_reg    <= '0;
            first_reg     <= 1'b1;
            spin_reg      <= 1'b0;
            valid_reg     <= 1'b0;
        end else begin
            if (cmd.load) begin
                reverse_reg   <= reverse_next;
                turn_left_reg <= turn_left_next;
                attack_reg    <= attack_next;
                first_reg     <= first_next;
                spin_reg      <= spin_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pulse_neg_reg <= pulse_neg_next;
            fin_left_reg  <= fin_left_next;
            fin_right_reg <= fin_right_next;
            fin_hold_reg  <= fin_hold_next;
        end
        left_reg  <= left_next;
        right_reg <= right_next;
        hold_reg  <= hold_next;
        last_reg  <= last_next;
    end

    assign m_tvalid    = valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign hold_ms     = hold_reg;
    assign last_of_run = last_reg;

endmodule

>>> rtl/edge_and_target_drive_policy.sv
// ----------------------------------------------------------------------------
// edge_and_target_drive_policy
// Turns edge and range sensor snapshots into runs of drive commands.
//
//   channel  | dir | tdata bits (low first)                       | tlast
//   s_       | in  | edge_hits[3:0], range_hits[9:4], pad to 16   | -
//   m_       | out | left_drive[8:0], right_drive[17:9], hold[23:18] | last_of_run
//
// Once a request is taken, its commands leave one per cycle from the output
// register: 2*PULSE_COUNT+1 for an edge hit that is not a turn pair, else
// one, none for a request ignored during a side spin. The sequencer takes
// no new request until the closing command is in the output register.
// m_tready low holds both. Reset is synchronous, active low; s_tready is low.
// ----------------------------------------------------------------------------
module edge_and_target_drive_policy
    import etdp_pkg::*;
#(
    parameter int PULSE_COUNT = 7,
    parameter int ATTACK_HOLD = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // edge_hits, range_hits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // left_drive, right_drive, hold_ms
    output logic        m_tlast    // last_of_run
);

    etdp_cmd_t cmd;
    etdp_sts_t sts;
    drive_t    left_drive, right_drive;
    hold_t     hold_ms;

    etdp_ctrl #(
        .PULSE_COUNT (PULSE_COUNT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    etdp_datapath #(
        .ATTACK_HOLD (ATTACK_HOLD)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .edge_hits   (s_tdata[EDGE_W-1:0]),
        .range_hits  (s_tdata[EDGE_W+RANGE_W-1:EDGE_W]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .hold_ms     (hold_ms),
        .last_of_run (m_tlast)
    );

    assign m_tdata = {hold_ms, right_drive, left_drive};

`ifndef SYNTH
    // A snapshot that yields commands keeps the sequencer busy next cycle
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && sts.has_cmd) |=> !s_tready)
        else $error("sequencer idle after taking a snapshot with commands");

    // A pulse still waiting means the closing command is yet to come
    a_pulse_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("snapshot taken while a pulse train is unfinished");

    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_pulse, cmd.emit_final, cmd.load}))
        else $error("conflicting sequencer commands");
`endif

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for edge_and_target_drive_policy: a table of directed
// snapshots, then random ones, are pushed through the sensor stream while
// the command stream stalls on its own pattern. Each command is checked field
// by field against a local model of the drive policy or a typed table row.
// ----------------------------------------------------------------------------
module tb;
    import etdp_pkg::*;

    localparam int PULSES   = 7;
    localparam int ATK_HOLD = 5;
    localparam int N_RANDOM = 420;

    typedef struct packed {
        drive_t left;
        drive_t right;
        hold_t  hold;
        logic   last;
    } drive_cmd_t;

    typedef struct packed {
        logic [EDGE_W-1:0]  edge_in;
        logic [RANGE_W-1:0] range_in;
        logic               typed;
        drive_t             t_left;
        drive_t             t_right;
        hold_t              t_hold;
    } snap_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // Local copy of the policy flags
    logic               rev_dir;
    logic               turn_l;
    logic [ATK_W-1:0]   atk_cnt;
    logic               first_mv;
    logic               spin_wait;

    drive_cmd_t cmd_q[$];
    int         err_cnt   = 0;
    int         burst_left = 0;
    int unsigned rx_cycle = 0;

    snap_row_t dir_rows [0:26];

    edge_and_target_drive_policy #(
        .PULSE_COUNT(PULSES),
        .ATTACK_HOLD(ATK_HOLD)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void push_cmd(int l, int r, int h);
        drive_cmd_t c;
        c.left  = drive_t'(l);
        c.right = drive_t'(r);
        c.hold  = hold_t'(h);
        c.last  = 1'b0;
        cmd_q.push_back(c);
    endfunction

    function automatic void pulse_train(int speed);
        for (int i = 0; i < PULSES; i++) begin
            push_cmd(speed, speed, 3);
            push_cmd(0, 0, 3);
        end
    endfunction

    // Work out the commands of one snapshot; returns how many were queued
    function automatic int predict_drive(logic [EDGE_W-1:0] e, logic [RANGE_W-1:0] r);
        int         sg;
        int         n0;
        drive_cmd_t c;
        logic       fl, fr, rr, rl, fpair, rpair;
        fl    = e[0];
        fr    = e[1];
        rr    = e[2];
        rl    = e[3];
        fpair = r[0] && r[1];
        rpair = r[3] && r[4];
        sg    = rev_dir ? 1 : -1;
        n0    = cmd_q.size();

        // a spin ignores anything but a front/rear range hit or an edge
        if (spin_wait) begin
            if (!r[0] && !r[1] && !r[3] && !r[4] && e == '0)
                return 0;
            spin_wait = 1'b0;
        end

        if (fl && rl) begin
            push_cmd(-100, 100, 30);
            rev_dir = 1'b1;
        end else if (fr && rr) begin
            push_cmd(100, -100, 30);
            rev_dir = 1'b0;
        end else if (fl) begin
            pulse_train(-200);
            if (first_mv) push_cmd(-200, -100, 60);
            else          push_cmd(-180, -120, 20);
            rev_dir  = 1'b0;
            first_mv = 1'b0;
        end else if (fr) begin
            pulse_train(-200);
            if (first_mv) push_cmd(-100, -200, 60);
            else          push_cmd(-120, -180, 20);
            rev_dir  = 1'b0;
            first_mv = 1'b0;
        end else if (rr) begin
            pulse_train(200);
            if (first_mv) push_cmd(200, 100, 60);
            else          push_cmd(180, 120, 30);
            rev_dir  = 1'b1;
            first_mv = 1'b0;
        end else if (rl) begin
            pulse_train(200);
            if (first_mv) push_cmd(100, 200, 60);
            else          push_cmd(120, 180, 30);
            rev_dir  = 1'b1;
            first_mv = 1'b0;
        end else if (atk_cnt != '0 && !fpair && !rpair) begin
            push_cmd(0, 0, 2);
            atk_cnt = atk_cnt - 1'b1;
        end else if (fpair) begin
            rev_dir = 1'b0;
            push_cmd(140, 140, 0);
            atk_cnt = ATK_W'(ATK_HOLD);
        end else if (r[0]) begin
            rev_dir = 1'b0;
            push_cmd(110, 70, 0);
            turn_l = 1'b1;
        end else if (r[1]) begin
            rev_dir = 1'b0;
            push_cmd(70, 110, 0);
            turn_l = 1'b0;
        end else if (rpair) begin
            rev_dir = 1'b1;
            push_cmd(-140, -140, 0);
            atk_cnt = ATK_W'(ATK_HOLD);
        end else if (r[4]) begin
            rev_dir = 1'b1;
            push_cmd(-110, -70, 0);
            turn_l = 1'b1;
        end else if (r[3]) begin
            rev_dir = 1'b1;
            push_cmd(-70, -110, 0);
            turn_l = 1'b0;
        end else if (first_mv) begin
            if (turn_l) push_cmd(140 * sg, 180 * sg, 50);
            else        push_cmd(180 * sg, 140 * sg, 50);
            first_mv = 1'b0;
        end else if (r[2]) begin
            turn_l = 1'b0;
            push_cmd(120, -70, 0);
            spin_wait = 1'b1;
        end else if (r[5]) begin
            turn_l = 1'b1;
            push_cmd(-120, 70, 0);
            spin_wait = 1'b1;
        end else begin
            if (turn_l) push_cmd(60 * sg, 80 * sg, 0);
            else        push_cmd(80 * sg, 60 * sg, 0);
        end

        if (cmd_q.size() > n0) begin
            c = cmd_q.pop_back();
            c.last = 1'b1;
            cmd_q.push_back(c);
        end
        return cmd_q.size() - n0;
    endfunction

    // Offer one snapshot, idling between bursts, and hold it until taken
    task automatic send_snapshot(logic [EDGE_W-1:0] e, logic [RANGE_W-1:0] r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, r, e};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    function automatic logic [EDGE_W-1:0] rand_edge();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)      return '0;
        else if (k < 9) return EDGE_W'(1 << $urandom_range(0, EDGE_W - 1));
        else            return EDGE_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [RANGE_W-1:0] rand_range();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)      return '0;
        else if (k < 7) return RANGE_W'(1 << $urandom_range(0, RANGE_W - 1));
        else            return RANGE_W'($urandom_range(0, 63));
    endfunction

    function automatic void check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endfunction

    // Receiver stall pattern: cycles through ready, coin toss, sparse, periodic
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[8:7])
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
            end
        endcase
    end

    always @(posedge aclk) begin
        drive_cmd_t c;
        if (aresetn && m_tvalid && m_tready) begin
            if (cmd_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected command, expected none, got %0d %0d %0d %0b",
                         $time, $signed(m_tdata[8:0]), $signed(m_tdata[17:9]),
                         m_tdata[23:18], m_tlast);
            end else begin
                c = cmd_q.pop_front();
                check_field("left_drive", c.left, $signed(m_tdata[8:0]));
                check_field("right_drive", c.right, $signed(m_tdata[17:9]));
                check_field("hold_ms", c.hold, m_tdata[23:18]);
                check_field("last_of_run", c.last, m_tlast);
            end
        end
    end

    initial begin
        int         n;
        int         runs;
        int         waited;
        drive_cmd_t c;
        logic [EDGE_W-1:0]  e;
        logic [RANGE_W-1:0] r;

        dir_rows = '{
            '{4'd0,  6'd1,  1'b1,  9'sd110,   9'sd70, 6'd0 },   // steer left, turn flag set
            '{4'd0,  6'd16, 1'b1, -9'sd110,  -9'sd70, 6'd0 },   // rear steer, reverse set
            '{4'd0,  6'd0,  1'b1,  9'sd140,  9'sd180, 6'd50},   // opening move, forward left
            '{4'd0,  6'd0,  1'b1,   9'sd60,   9'sd80, 6'd0 },   // search arc
            '{4'd0,  6'd8,  1'b1,  -9'sd70, -9'sd110, 6'd0 },
            '{4'd0,  6'd2,  1'b1,   9'sd70,  9'sd110, 6'd0 },
            '{4'd0,  6'd0,  1'b1,  -9'sd80,  -9'sd60, 6'd0 },   // search arc backward right
            '{4'd9,  6'd0,  1'b1, -9'sd100,  9'sd100, 6'd30},   // left edge pair
            '{4'd6,  6'd0,  1'b1,  9'sd100, -9'sd100, 6'd30},   // right edge pair
            '{4'd1,  6'd0,  1'b0,    9'sd0,    9'sd0, 6'd0 },   // pulse trains
            '{4'd2,  6'd0,  1'b0,    9'sd0,    9'sd0, 6'd0 },
            '{4'd4,  6'd0,  1'b0,    9'sd0,    9'sd0, 6'd0 },
            '{4'd8,  6'd0,  1'b0,    9'sd0,    9'sd0, 6'd0 },
            '{4'd0,  6'd3,  1'b1,  9'sd140,  9'sd140, 6'd0 },   // charge arms countdown
            '{4'd0,  6'd0,  1'b1,    9'sd0,    9'sd0, 6'd2 },   // stop pulse
            '{4'd0,  6'd24, 1'b1, -9'sd140, -9'sd140, 6'd0 },   // rear charge
            '{4'd0,  6'd63, 1'b0,    9'sd0,    9'sd0, 6'd0 },
            '{4'd0,  6'd4,  1'b0,    9'sd0,    9'sd0, 6'd0 },
            '{4'd0,  6'd0,  1'b0,    9'sd0,    9'sd0, 6'd0 },
            '{4'd0,  6'd0,  1'b0,    9'sd0,    9'sd0, 6'd0 },
            '{4'd0,  6'd0,  1'b0,    9'sd0,    9'sd0, 6'd0 },
            '{4'd0,  6'd0,  1'b0,    9'sd0,    9'sd0, 6'd0 },   // countdown drained
            '{4'd0,  6'd4,  1'b0,    9'sd0,    9'sd0, 6'd0 },   // side spin starts
            '{4'd0,  6'd36, 1'b0,    9'sd0,    9'sd0, 6'd0 },   // ignored while spinning
            '{4'd0,  6'd1,  1'b0,    9'sd0,    9'sd0, 6'd0 },   // front hit ends spin
            '{4'd0,  6'd32, 1'b0,    9'sd0,    9'sd0, 6'd0 },
            '{4'd15, 6'd0,  1'b1, -9'sd100,  9'sd100, 6'd30}    // edge hit ends spin
        };

        rev_dir   = 1'b0;
        turn_l    = 1'b0;
        atk_cnt   = '0;
        first_mv  = 1'b1;
        spin_wait = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_snapshot(dir_rows[i].edge_in, dir_rows[i].range_in);
            n = predict_drive(dir_rows[i].edge_in, dir_rows[i].range_in);
            if (dir_rows[i].typed) begin
                // swap the modelled command for the one read off the table
                repeat (n) void'(cmd_q.pop_back());
                c.left  = dir_rows[i].t_left;
                c.right = dir_rows[i].t_right;
                c.hold  = dir_rows[i].t_hold;
                c.last  = 1'b1;
                cmd_q.push_back(c);
            end
        end

        runs = 0;
        while (runs < N_RANDOM) begin
            if (runs == N_RANDOM / 2) begin
                // drain the command stream before offering more
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (cmd_q.size() != 0) @(posedge aclk);
            end
            e = rand_edge();
            r = rand_range();
            send_snapshot(e, r);
            if (predict_drive(e, r) > 0)
                runs++;
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (cmd_q.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (32) @(posedge aclk);

        if (err_cnt == 0 && cmd_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (cmd_q.size() != 0)
                $display("%0t: %0d commands never arrived, expected 0 pending",
                         $time, cmd_q.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
